// ===== hw/rtl/lru_td_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_td_pkg
// Shared defaults, fixed field widths and the control bundle that the
// directory broadcasts to every cell.
// ----------------------------------------------------------------------------
package lru_td_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int KEY_BITS_DEF  = 32;

	// Width of the slot field on the result port; wider slot indexes are truncated.
	localparam int SLOT_BITS = 4;

	// Command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// Per-cycle control broadcast to all cells
	typedef struct packed {
		logic go;        // an item is processed this cycle
		logic flush;     // the item is a flush
		logic hit_any;   // some cell matched the key
		logic free_any;  // some cell is unused
		logic sel_used;  // the selected cell held an entry
	} cell_ctl_t;

endpackage

// ===== hw/rtl/lru_td_cell.sv =====
// ----------------------------------------------------------------------------
// lru_td_cell
// One directory slot: stored key, used flag and age. Hands the "match seen"
// and "free seen" flags on to its right neighbor.
// ----------------------------------------------------------------------------
module lru_td_cell #(
	parameter int KEY_BITS  = lru_td_pkg::KEY_BITS_DEF,
	parameter int NUM_SLOTS = lru_td_pkg::NUM_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lru_td_pkg::cell_ctl_t        ctl,
	input  logic [KEY_BITS-1:0]          key,
	input  logic [$clog2(NUM_SLOTS)-1:0] sel_rank,
	input  logic                         hit_in,
	input  logic                         free_in,
	output logic                         hit_out,
	output logic                         free_out,
	output logic                         sel,
	output logic                         used,
	output logic [$clog2(NUM_SLOTS)-1:0] rank
);

	localparam int RANK_BITS = $clog2(NUM_SLOTS);

	logic [KEY_BITS-1:0]  key_q;
	logic                 used_q;
	logic [RANK_BITS-1:0] rank_q;
	logic                 match;
	logic                 first_hit;
	logic                 first_free;
	logic                 oldest;

	assign match      = (key_q == key);
	assign first_hit  = match & ~hit_in;
	assign hit_out    = hit_in | match;
	assign first_free = ~used_q & ~free_in;
	assign free_out   = free_in | ~used_q;
	// With every slot used the ages are a permutation, so exactly one is oldest
	assign oldest     = used_q & (rank_q == RANK_BITS'(NUM_SLOTS - 1));

	always_comb begin
		if (ctl.hit_any) begin
			sel = first_hit;
		end else if (ctl.free_any) begin
			sel = first_free;
		end else begin
			sel = oldest;
		end
	end

	assign used = used_q;
	assign rank = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			used_q <= 1'b0;
			rank_q <= '0;
		end else if (ctl.go) begin
			if (ctl.flush) begin
				key_q  <= '0;
				used_q <= 1'b0;
				rank_q <= '0;
			end else if (sel) begin
				key_q  <= key;
				used_q <= 1'b1;
				rank_q <= '0;
			end else if (used_q && (!ctl.sel_used || rank_q < sel_rank)) begin
				// age by one behind the newly touched slot
				rank_q <= rank_q + RANK_BITS'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/lru_tag_directory_top.sv =====
// ----------------------------------------------------------------------------
// lru_tag_directory_top
// Tag directory of a fully associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and
//   busy low. cmd selects a lookup of key or a flush of the whole directory.
//   Result channel: done is high for exactly one cycle per command, with
//   hit, slot and victim_was_used valid in that cycle. The receiver cannot
//   stall; each result must be taken in the cycle it is shown.
//   A command taken at a rising edge is held in the s1 registers and evaluated
//   in the following cycle; its result is registered into done, hit, slot and
//   victim_was_used and shown on the ports.
//   Throughput: one command per cycle while busy is low. The next command is
//   compared against the directory as updated by the previous one, since each
//   evaluation across the row of slot cells updates them before the next one.
//   The critical path is the key compare plus the priority chain that runs
//   through all NUM_SLOTS cells, followed by the age update.
//   On a miss the victim is the lowest unused slot, else the oldest slot.
//   Reset: all keys, used flags and ages clear at once; busy is high for the
//   first cycle after reset release, then stays low.
// ----------------------------------------------------------------------------
module lru_tag_directory_top #(
	parameter int NUM_SLOTS = lru_td_pkg::NUM_SLOTS_DEF,
	parameter int KEY_BITS  = lru_td_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic [31:0]                    key,
	output logic                           done,
	output logic                           hit,
	output logic [lru_td_pkg::SLOT_BITS-1:0] slot,
	output logic                           victim_was_used
);

	localparam int RANK_BITS = $clog2(NUM_SLOTS);

	logic                  busy_q;
	logic                  go_s1;
	logic                  flush_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [KEY_BITS-1:0]   key_in;

	logic                  done_q;
	logic                  hit_q;
	logic [lru_td_pkg::SLOT_BITS-1:0] slot_q;
	logic                  vic_q;

	logic [NUM_SLOTS:0]    hit_chain;
	logic [NUM_SLOTS:0]    free_chain;
	logic [NUM_SLOTS-1:0]  sel_vec;
	logic [NUM_SLOTS-1:0]  used_vec;
	logic [RANK_BITS-1:0]  rank_vec [NUM_SLOTS];

	lru_td_pkg::cell_ctl_t ctl;
	logic                  sel_used;
	logic [RANK_BITS-1:0]  sel_rank;
	logic [RANK_BITS-1:0]  sel_idx;

	// Truncate the incoming key to the configured width, or zero-extend it when KEY_BITS exceeds 32
	if (KEY_BITS >= 32) begin : g_key_wide
		assign key_in = KEY_BITS'(key);
	end else begin : g_key_narrow
		assign key_in = key[KEY_BITS-1:0];
	end

	assign busy = busy_q;

	// Hold the accepted command in the s1 registers for its evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			go_s1  <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			go_s1  <= start & ~busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			flush_s1 <= (cmd == lru_td_pkg::CMD_FLUSH);
			key_s1   <= key_in;
		end
	end

	// Ends of the priority chains
	assign hit_chain[0]  = 1'b0;
	assign free_chain[0] = 1'b0;

	assign ctl.go       = go_s1;
	assign ctl.flush    = flush_s1;
	assign ctl.hit_any  = hit_chain[NUM_SLOTS];
	assign ctl.free_any = free_chain[NUM_SLOTS];
	assign ctl.sel_used = sel_used;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		lru_td_cell #(
			.KEY_BITS (KEY_BITS),
			.NUM_SLOTS(NUM_SLOTS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.key     (key_s1),
			.sel_rank(sel_rank),
			.hit_in  (hit_chain[i]),
			.free_in (free_chain[i]),
			.hit_out (hit_chain[i+1]),
			.free_out(free_chain[i+1]),
			.sel     (sel_vec[i]),
			.used    (used_vec[i]),
			.rank    (rank_vec[i])
		);
	end

	// Gather the selected cell's state and index; exactly one cell is selected
	always_comb begin
		sel_used = 1'b0;
		sel_rank = '0;
		sel_idx  = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sel_used = sel_used | (sel_vec[i] & used_vec[i]);
			sel_rank = sel_rank | (rank_vec[i] & {RANK_BITS{sel_vec[i]}});
			sel_idx  = sel_idx | (RANK_BITS'(i) & {RANK_BITS{sel_vec[i]}});
		end
	end

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			if (flush_s1) begin
				hit_q  <= 1'b0;
				slot_q <= '0;
				vic_q  <= 1'b0;
			end else begin
				hit_q  <= ctl.hit_any;
				slot_q <= lru_td_pkg::SLOT_BITS'(sel_idx);
				vic_q  <= ~ctl.hit_any & sel_used;
			end
		end
	end

	assign done            = done_q;
	assign hit             = hit_q;
	assign slot            = slot_q;
	assign victim_was_used = vic_q;

endmodule
